>>> sv/ptd_pkg.sv
`default_nettype none

package ptd_pkg;

    localparam int DEF_NUM_WIDTH = 32;
    localparam int CAND_WIDTH    = 32;
    localparam int IN_TDATA_W    = 32;
    localparam int OUT_TDATA_W   = 40;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;

    localparam int FIRST_DIV = 5;
    localparam int FIRST_SQ  = 25;
    localparam int WHEEL     = 6;
    localparam int SQ_ADD    = 36;

    typedef enum logic [1:0] {
        CLS_COMPOSITE,
        CLS_PRIME,
        CLS_TEST
    } t_cls;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_st;

endpackage

`default_nettype wire

>>> sv/prime_test_trial_division.sv
// primality test by trial division over the 6k +/- 1 wheel
// input beat: i_s_tdata holds the candidate; it is cut or zero-extended to
// NUM_WIDTH bits before the test
// output beat: o_m_tdata bit 0 is_prime, bits 32:1 the value tested (low 32 bits)
// one output beat per input beat, in order
// the front end classifies a beat in the cycle it is taken and places it in a
// four-entry queue, so up to four candidates are taken while the back end works
// values below two, two, three and even values are answered without division,
// going from the head of the queue via S_IDLE and S_OUT to the output register
// other values run rounds on two bit-serial dividers working side by side: a
// first round by three, then one round per pair d, d+2 while d*d <= n
// each round runs the one-bit-a-cycle remainder loop over all NUM_WIDTH bits
// of the candidate; a prime runs rounds until d*d exceeds n
// a stalled output holds its beat; the back end takes the next candidate once
// its result is in the output register and stops only when that is still full
// reset (synchronous, active low) empties the queue and drops any pending beat
`default_nettype none

module prime_test_trial_division #(
    parameter int NUM_WIDTH = ptd_pkg::DEF_NUM_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [ptd_pkg::IN_TDATA_W-1:0] i_s_tdata,  // candidate
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [ptd_pkg::OUT_TDATA_W-1:0]     o_m_tdata   // is_prime, tested_value
);
    import ptd_pkg::*;

    localparam int EW = NUM_WIDTH + 2;

    logic                  w_full;
    logic                  w_push;
    logic [EW-1:0]         w_entry_in;
    logic                  w_pop;
    logic                  w_valid;
    logic [EW-1:0]         w_entry_out;
    logic                  w_start;
    logic [NUM_WIDTH-1:0]  w_dividend;
    logic [NUM_WIDTH-1:0]  w_div_a;
    logic [NUM_WIDTH-1:0]  w_div_b;
    t_rem_st               w_st_a;
    t_rem_st               w_st_b;
    logic [NUM_WIDTH-1:0]  w_rem_a;
    logic [NUM_WIDTH-1:0]  w_rem_b;
    logic                  w_is_prime;
    logic [CAND_WIDTH-1:0] w_tested;

    ptd_front #(.NUM_WIDTH(NUM_WIDTH)) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_entry    (w_entry_in)
    );

    ptd_fifo #(.WIDTH(EW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_entry_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_valid),
        .o_data  (w_entry_out)
    );

    ptd_rem #(.NUM_WIDTH(NUM_WIDTH)) u_rem_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_div_a),
        .o_st       (w_st_a),
        .o_rem      (w_rem_a)
    );

    ptd_rem #(.NUM_WIDTH(NUM_WIDTH)) u_rem_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_div_b),
        .o_st       (w_st_b),
        .o_rem      (w_rem_b)
    );

    ptd_back #(.NUM_WIDTH(NUM_WIDTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_entry    (w_entry_out),
        .o_pop      (w_pop),
        .o_start    (w_start),
        .o_dividend (w_dividend),
        .o_div_a    (w_div_a),
        .o_div_b    (w_div_b),
        .i_st_a     (w_st_a),
        .i_rem_a    (w_rem_a),
        .i_rem_b    (w_rem_b),
        .o_tvalid   (o_m_tvalid),
        .i_tready   (i_m_tready),
        .o_is_prime (w_is_prime),
        .o_tested   (w_tested)
    );

    assign o_m_tdata = {{(OUT_TDATA_W - CAND_WIDTH - 1){1'b0}}, w_tested, w_is_prime};

`ifndef NO_ASSERTIONS
    a_rem_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_st_a.done == w_st_b.done) && (w_st_a.busy == w_st_b.busy))
        else $error("remainder units out of step");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_st_a.busy && !w_st_b.busy)
        else $error("division started while busy");

    a_prime_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> o_m_tdata[1] || (w_tested == CAND_WIDTH'(2)))
        else $error("even value other than two reported prime");
`endif

endmodule

`default_nettype wire

>>> sv/ptd_front.sv
`default_nettype none

module ptd_front #(
    parameter int NUM_WIDTH = ptd_pkg::DEF_NUM_WIDTH
) (
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [ptd_pkg::IN_TDATA_W-1:0]    i_s_tdata,  // candidate
    input  wire logic                              i_full,
    output logic                                   o_push,
    output logic [NUM_WIDTH+1:0]                   o_entry
);
    import ptd_pkg::*;

    logic [NUM_WIDTH-1:0] w_n;
    t_cls                 w_cls;

    assign w_n = NUM_WIDTH'(i_s_tdata);

    always_comb begin
        if (w_n <= NUM_WIDTH'(1)) begin
            w_cls = CLS_COMPOSITE;
        end else if (w_n == NUM_WIDTH'(2) || w_n == NUM_WIDTH'(3)) begin
            w_cls = CLS_PRIME;
        end else if (!w_n[0]) begin
            w_cls = CLS_COMPOSITE;
        end else begin
            // odd, five or more: divisibility by three is left to the back end
            w_cls = CLS_TEST;
        end
    end

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign o_entry    = {w_cls, w_n};

endmodule

`default_nettype wire

>>> sv/ptd_fifo.sv
`default_nettype none

module ptd_fifo #(
    parameter int WIDTH = ptd_pkg::DEF_NUM_WIDTH + 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    import ptd_pkg::*;

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                w_pop;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/ptd_rem.sv
`default_nettype none

module ptd_rem #(
    parameter int NUM_WIDTH = ptd_pkg::DEF_NUM_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [NUM_WIDTH-1:0] i_dividend,
    input  wire logic [NUM_WIDTH-1:0] i_divisor,
    output ptd_pkg::t_rem_st          o_st,
    output logic [NUM_WIDTH-1:0]      o_rem
);
    import ptd_pkg::*;

    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] r_q;
    logic [NUM_WIDTH-1:0] r_d;
    logic [NUM_WIDTH-1:0] r_r;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic [NUM_WIDTH:0]   w_trial;
    logic [NUM_WIDTH:0]   w_diff;
    logic                 w_done;

    // restoring division, one quotient bit a cycle, most significant first
    assign w_trial = {r_r, r_q[NUM_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_done  = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NUM_WIDTH);
            r_q    <= i_dividend;
            r_d    <= i_divisor;
            r_r    <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_q   <= {r_q[NUM_WIDTH-2:0], 1'b0};
            if (!w_diff[NUM_WIDTH]) begin
                r_r <= w_diff[NUM_WIDTH-1:0];
            end else begin
                r_r <= w_trial[NUM_WIDTH-1:0];
            end
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = w_done;
    assign o_rem     = r_r;

endmodule

`default_nettype wire

>>> sv/ptd_back.sv
`default_nettype none

module ptd_back #(
    parameter int NUM_WIDTH = ptd_pkg::DEF_NUM_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic [NUM_WIDTH+1:0]              i_entry,
    output logic                                   o_pop,
    output logic                                   o_start,
    output logic [NUM_WIDTH-1:0]                   o_dividend,
    output logic [NUM_WIDTH-1:0]                   o_div_a,
    output logic [NUM_WIDTH-1:0]                   o_div_b,
    input  wire ptd_pkg::t_rem_st                  i_st_a,
    input  wire logic [NUM_WIDTH-1:0]              i_rem_a,
    input  wire logic [NUM_WIDTH-1:0]              i_rem_b,
    output logic                                   o_tvalid,
    input  wire logic                              i_tready,
    output logic                                   o_is_prime,
    output logic [ptd_pkg::CAND_WIDTH-1:0]         o_tested
);
    import ptd_pkg::*;

    localparam int SW = NUM_WIDTH + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_CHK,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [NUM_WIDTH-1:0] r_n;
    logic [NUM_WIDTH-1:0] r_d;
    logic [SW-1:0]        r_sq;
    logic                 r_pre;
    logic                 r_start;
    logic [NUM_WIDTH-1:0] r_dva;
    logic [NUM_WIDTH-1:0] r_dvb;
    logic                 r_res;
    logic                 r_ovalid;
    logic                 r_oprime;
    logic [CAND_WIDTH-1:0] r_otest;
    t_cls                 w_cls;
    logic [SW-1:0]        w_d_ext;
    logic [SW-1:0]        n_sq;
    logic                 n_start;
    logic                 w_load;

    assign w_cls   = t_cls'(i_entry[NUM_WIDTH+1:NUM_WIDTH]);
    assign w_d_ext = SW'(r_d);
    // (d + 6)^2 = d^2 + 12d + 36
    assign n_sq    = r_sq + (w_d_ext << 3) + (w_d_ext << 2) + SW'(SQ_ADD);
    assign o_pop   = (r_state == S_IDLE) && i_valid;
    assign w_load  = (r_state == S_OUT) && (!r_ovalid || i_tready);
    assign n_start = ((r_state == S_IDLE) && i_valid && (w_cls == CLS_TEST))
                  || ((r_state == S_CHK) && (r_sq <= SW'(r_n)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= n_start;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_n <= i_entry[NUM_WIDTH-1:0];
                        case (w_cls)
                            CLS_PRIME: begin
                                r_res   <= 1'b1;
                                r_state <= S_OUT;
                            end
                            CLS_TEST: begin
                                r_d     <= NUM_WIDTH'(FIRST_DIV);
                                r_sq    <= SW'(FIRST_SQ);
                                r_pre   <= 1'b1;
                                r_dva   <= NUM_WIDTH'(3);
                                r_dvb   <= NUM_WIDTH'(3);
                                r_state <= S_DIV;
                            end
                            default: begin
                                r_res   <= 1'b0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (i_st_a.done) begin
                        if (i_rem_a == '0 || (!r_pre && i_rem_b == '0)) begin
                            r_res   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            if (r_pre) begin
                                r_pre <= 1'b0;
                            end else begin
                                r_d  <= r_d + NUM_WIDTH'(WHEEL);
                                r_sq <= n_sq;
                            end
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    if (r_sq > SW'(r_n)) begin
                        r_res   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_dva   <= r_d;
                        r_dvb   <= r_d + NUM_WIDTH'(2);
                        r_state <= S_DIV;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_oprime <= r_res;
                        r_otest  <= CAND_WIDTH'(r_n);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_start    = r_start;
    assign o_dividend = r_n;
    assign o_div_a    = r_dva;
    assign o_div_b    = r_dvb;
    assign o_tvalid   = r_ovalid;
    assign o_is_prime = r_oprime;
    assign o_tested   = r_otest;

endmodule

`default_nettype wire
